// ----- hdl/sd_spi_command_engine_top_defines.svh -----
// assertion macros used by the sd spi command engine core
`ifndef SD_SPI_COMMAND_ENGINE_TOP_DEFINES_SVH
`define SD_SPI_COMMAND_ENGINE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDSPI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SDSPI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/sdspi_pkg.sv -----
// types and constants of the sd spi command engine
`default_nettype none
package sdspi_pkg;

	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 16;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_READY_LIMIT     = 1'b0,
		CFG_RESP_POLL_LIMIT = 1'b1
	} cfg_idx_t;

	localparam logic [15:0] READY_LIMIT_RST = 16'd50000;
	localparam logic [7:0] RESP_POLL_LIMIT_RST = 8'd255;

	localparam logic REQ_COMMAND = 1'b0;
	localparam logic REQ_RX_BYTE = 1'b1;
	localparam logic KIND_XFER = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [5:0] CMD_GO_IDLE = 6'd0;
	localparam logic [5:0] CMD_IF_COND = 6'd8;
	localparam logic [5:0] CMD_STOP = 6'd12;
	localparam logic [5:0] CMD_APP = 6'd55;

	localparam logic [7:0] BYTE_FILL = 8'hFF;
	localparam logic [7:0] CRC_GO_IDLE = 8'h95;
	localparam logic [7:0] CRC_IF_COND = 8'h87;
	localparam logic [7:0] CRC_DUMMY = 8'h01;
	localparam logic [1:0] FRAME_START = 2'b01;
	localparam logic [2:0] FRAME_LAST = 3'd5;

	typedef enum logic [7:0] {
		PH_IDLE    = 8'b0000_0001,
		PH_DESEL   = 8'b0000_0010,
		PH_SEL     = 8'b0000_0100,
		PH_READY   = 8'b0000_1000,
		PH_FRAME   = 8'b0001_0000,
		PH_DISCARD = 8'b0010_0000,
		PH_RESP    = 8'b0100_0000,
		PH_TOUT    = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic        req_type;
		logic [5:0]  cmd_index;
		logic        app_cmd;
		logic [31:0] cmd_arg;
		logic [7:0]  rx_byte;
	} req_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] tx_byte;
		logic       cs_low;
		logic [7:0] response;
		logic       timed_out;
	} rsp_t;

	typedef struct packed {
		logic [15:0] ready_limit;
		logic [7:0]  resp_poll_limit;
	} cfg_t;

	typedef struct packed {
		logic valid;
		rsp_t item;
	} result_t;

endpackage
`default_nettype wire

// ----- hdl/sdspi_core.sv -----
// input register and command sequencer of the sd spi command engine
`default_nettype none
`include "sd_spi_command_engine_top_defines.svh"
module sdspi_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  sdspi_pkg::req_t  req,
	input  sdspi_pkg::cfg_t  cfg,
	input  logic             take,
	output sdspi_pkg::result_t result
);
	import sdspi_pkg::*;

	logic        s1_valid_q;
	req_t        req_s1;
	phase_t      phase_q, phase_d;
	logic [2:0]  byte_count_q, byte_count_d;
	logic [15:0] poll_count_q, poll_count_d;
	logic [5:0]  saved_index_q, saved_index_d;
	logic [31:0] saved_arg_q, saved_arg_d;
	logic        prefix_q, prefix_d;
	logic        cs_q, cs_d;
	logic        advance;

	function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] idx,
			input logic [31:0] arg);
		logic [7:0] b;
		unique case (k)
			3'd0: b = {FRAME_START, idx};
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: begin
				priority if (idx == CMD_GO_IDLE) b = CRC_GO_IDLE;
				else if (idx == CMD_IF_COND) b = CRC_IF_COND;
				else b = CRC_DUMMY;
			end
		endcase
		return b;
	endfunction

	function automatic rsp_t xfer(input logic [7:0] tx, input logic cs);
		rsp_t r;
		r = '0;
		r.out_kind = KIND_XFER;
		r.tx_byte = tx;
		r.cs_low = cs;
		return r;
	endfunction

	assign advance = s1_valid_q && take;
	assign req_ready = !s1_valid_q || take;

	always_comb begin
		logic        do_begin;
		logic        do_done;
		logic [7:0]  done_resp;
		logic        done_to;
		logic [5:0]  cur_idx;
		logic [5:0]  beg_idx;
		logic [31:0] cur_arg;
		logic [31:0] beg_arg;
		logic [15:0] poll_inc;
		logic [8:0]  lim;
		logic [2:0]  bc_inc;

		phase_d = phase_q;
		byte_count_d = byte_count_q;
		poll_count_d = poll_count_q;
		saved_index_d = saved_index_q;
		saved_arg_d = saved_arg_q;
		prefix_d = prefix_q;
		cs_d = cs_q;
		result = '0;
		do_begin = 1'b0;
		do_done = 1'b0;
		done_resp = '0;
		done_to = 1'b0;
		cur_idx = prefix_q ? CMD_APP : saved_index_q;
		cur_arg = prefix_q ? '0 : saved_arg_q;
		poll_inc = poll_count_q + 16'd1;
		lim = (cfg.resp_poll_limit == '0) ? 9'd256 : {1'b0, cfg.resp_poll_limit};
		bc_inc = byte_count_q + 3'd1;

		if (req_s1.req_type == REQ_COMMAND) begin
			saved_index_d = req_s1.cmd_index;
			prefix_d = req_s1.app_cmd;
			saved_arg_d = req_s1.cmd_arg;
			byte_count_d = '0;
			poll_count_d = '0;
			do_begin = 1'b1;
		end else begin
			unique case (phase_q)
				PH_DESEL: begin
					cs_d = 1'b1;
					phase_d = PH_SEL;
					result = {1'b1, xfer(BYTE_FILL, 1'b1)};
				end
				PH_SEL: begin
					phase_d = PH_READY;
					poll_count_d = '0;
					result = {1'b1, xfer(BYTE_FILL, cs_q)};
				end
				PH_READY: begin
					priority if (req_s1.rx_byte == BYTE_FILL) begin
						phase_d = PH_FRAME;
						byte_count_d = '0;
						result = {1'b1, xfer(frame_byte(3'd0, cur_idx, cur_arg), cs_q)};
					end else if (poll_count_q >= cfg.ready_limit) begin
						cs_d = 1'b0;
						phase_d = PH_TOUT;
						result = {1'b1, xfer(BYTE_FILL, 1'b0)};
					end else begin
						poll_count_d = poll_inc;
						result = {1'b1, xfer(BYTE_FILL, cs_q)};
					end
				end
				PH_FRAME: begin
					if (bc_inc <= FRAME_LAST) begin
						byte_count_d = bc_inc;
						result = {1'b1, xfer(frame_byte(bc_inc, cur_idx, cur_arg), cs_q)};
					end else begin
						byte_count_d = '0;
						poll_count_d = '0;
						phase_d = (cur_idx == CMD_STOP) ? PH_DISCARD : PH_RESP;
						result = {1'b1, xfer(BYTE_FILL, cs_q)};
					end
				end
				PH_DISCARD: begin
					phase_d = PH_RESP;
					poll_count_d = '0;
					result = {1'b1, xfer(BYTE_FILL, cs_q)};
				end
				PH_RESP: begin
					priority if (!req_s1.rx_byte[7]) begin
						do_done = 1'b1;
						done_resp = req_s1.rx_byte;
					end else if (poll_inc >= {7'd0, lim}) begin
						poll_count_d = poll_inc;
						do_done = 1'b1;
						done_resp = req_s1.rx_byte;
					end else begin
						poll_count_d = poll_inc;
						result = {1'b1, xfer(BYTE_FILL, cs_q)};
					end
				end
				PH_TOUT: begin
					do_done = 1'b1;
					done_resp = BYTE_FILL;
					done_to = 1'b1;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end

		if (do_done) begin
			if (prefix_q && done_resp <= 8'd1 && !done_to) begin
				prefix_d = 1'b0;
				do_begin = 1'b1;
			end else begin
				prefix_d = 1'b0;
				phase_d = PH_IDLE;
				result.valid = 1'b1;
				result.item = '0;
				result.item.out_kind = KIND_DONE;
				result.item.cs_low = cs_q;
				result.item.response = done_resp;
				result.item.timed_out = done_to;
			end
		end

		beg_idx = prefix_d ? CMD_APP : saved_index_d;
		beg_arg = prefix_d ? '0 : saved_arg_d;
		if (do_begin) begin
			if (beg_idx != CMD_STOP) begin
				cs_d = 1'b0;
				phase_d = PH_DESEL;
				result = {1'b1, xfer(BYTE_FILL, 1'b0)};
			end else begin
				phase_d = PH_FRAME;
				byte_count_d = '0;
				result = {1'b1, xfer(frame_byte(3'd0, beg_idx, beg_arg), cs_d)};
			end
		end

		result.valid = result.valid && s1_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_ready) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			byte_count_q <= '0;
			poll_count_q <= '0;
			saved_index_q <= '0;
			saved_arg_q <= '0;
			prefix_q <= 1'b0;
			cs_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			byte_count_q <= byte_count_d;
			poll_count_q <= poll_count_d;
			saved_index_q <= saved_index_d;
			saved_arg_q <= saved_arg_d;
			prefix_q <= prefix_d;
			cs_q <= cs_d;
		end
	end

	`SDSPI_ASSERT_NEXT(a_cmd_starts, advance && req_s1.req_type == REQ_COMMAND, phase_q != PH_IDLE, "command transaction left engine idle")
	`SDSPI_ASSERT_NOW(a_desel_cs_high, phase_q == PH_DESEL || phase_q == PH_TOUT, !cs_q, "chip select asserted while deselecting")
	`SDSPI_ASSERT_NOW(a_frame_count, phase_q == PH_FRAME, byte_count_q <= FRAME_LAST, "frame byte count out of range")
	`SDSPI_ASSERT_NOW(a_resp_polls, phase_q == PH_RESP, poll_count_q < 16'd256, "response poll count past limit")

endmodule
`default_nettype wire

// ----- hdl/sdspi_out_buf.sv -----
// result register of the sd spi command engine
`default_nettype none
module sdspi_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  sdspi_pkg::result_t result,
	output logic               take,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output sdspi_pkg::rsp_t    rsp
);
	import sdspi_pkg::*;

	logic valid_q;
	rsp_t data_q;

	assign take = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && result.valid) begin
			data_q <= result.item;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/sd_spi_command_engine_top.sv -----
// a transaction is held in the input register, and its result goes on into the result register
// throughput: one transaction per cycle while results are taken, set by the single-pass sequencer step
// a transaction that causes no result still takes its slot in the input register
// reset: asynchronous active low; sequencer idle, chip select released,
// ready_limit 50000 and resp_poll_limit 255
`default_nettype none
module sd_spi_command_engine_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  sdspi_pkg::req_t                   req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output sdspi_pkg::rsp_t                   rsp,
	input  logic                              wr_en,
	input  logic [sdspi_pkg::CfgIdxW-1:0]     wr_index,
	input  logic [sdspi_pkg::CfgDataW-1:0]    wr_data
);
	import sdspi_pkg::*;

	cfg_t    cfg_q;
	result_t result;
	logic    take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ready_limit <= READY_LIMIT_RST;
			cfg_q.resp_poll_limit <= RESP_POLL_LIMIT_RST;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_READY_LIMIT: cfg_q.ready_limit <= wr_data[15:0];
				CFG_RESP_POLL_LIMIT: cfg_q.resp_poll_limit <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	sdspi_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cfg       (cfg_q),
		.take      (take),
		.result    (result)
	);

	sdspi_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.take      (take),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ----- dv/sd_spi_command_engine_tb_pkg.sv -----
// scoreboard for the sd spi command engine testbench: exchange predictor and result check
`timescale 1ns / 100ps
package sd_spi_command_engine_tb_pkg;
	import sdspi_pkg::*;

	class spi_exchange_tracker;
		phase_t      phase;
		logic [2:0]  byte_count;
		logic [15:0] poll_count;
		logic [5:0]  saved_index;
		logic [31:0] saved_arg;
		logic        prefix_active;
		logic        cs_level;
		cfg_t        cfg;
		rsp_t        pending_exchanges[$];
		int          errors;

		function new();
			phase = PH_IDLE;
			byte_count = '0;
			poll_count = '0;
			saved_index = '0;
			saved_arg = '0;
			prefix_active = 1'b0;
			cs_level = 1'b0;
			cfg.ready_limit = READY_LIMIT_RST;
			cfg.resp_poll_limit = RESP_POLL_LIMIT_RST;
			errors = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] data);
			case (idx)
				CFG_READY_LIMIT: begin
					cfg.ready_limit = data;
				end
				CFG_RESP_POLL_LIMIT: begin
					cfg.resp_poll_limit = data[7:0];
				end
				default: begin
				end
			endcase
		endfunction

		function int pending();
			return pending_exchanges.size();
		endfunction

		function logic [5:0] active_index();
			return prefix_active ? CMD_APP : saved_index;
		endfunction

		function logic [7:0] frame_byte(logic [2:0] pos);
			logic [5:0]  idx;
			logic [31:0] arg;
			idx = active_index();
			arg = prefix_active ? 32'h0 : saved_arg;
			if (pos == 3'd0)
				return {FRAME_START, idx};
			if (pos <= 3'd4)
				return 8'(arg >> (8 * (4 - int'(pos))));
			if (idx == CMD_GO_IDLE)
				return CRC_GO_IDLE;
			if (idx == CMD_IF_COND)
				return CRC_IF_COND;
			return CRC_DUMMY;
		endfunction

		function void push_result(logic kind, logic [7:0] tx, logic cs, logic [7:0] resp,
				logic tout);
			rsp_t r;
			r.out_kind = kind;
			r.tx_byte = tx;
			r.cs_low = cs;
			r.response = resp;
			r.timed_out = tout;
			pending_exchanges.push_back(r);
		endfunction

		function void xfer(logic [7:0] tx, logic cs);
			push_result(KIND_XFER, tx, cs, 8'h00, 1'b0);
		endfunction

		function void start_command();
			if (active_index() != CMD_STOP) begin
				cs_level = 1'b0;
				phase = PH_DESEL;
				xfer(BYTE_FILL, 1'b0);
			end else begin
				phase = PH_FRAME;
				byte_count = '0;
				xfer(frame_byte(3'd0), cs_level);
			end
		endfunction

		function void complete(logic [7:0] res, logic tout);
			// a good CMD55 answer chains into the real command
			if (prefix_active && res <= 8'd1 && !tout) begin
				prefix_active = 1'b0;
				start_command();
				return;
			end
			prefix_active = 1'b0;
			phase = PH_IDLE;
			push_result(KIND_DONE, 8'h00, cs_level, res, tout);
		endfunction

		function void note_request(req_t it);
			int unsigned lim;
			if (it.req_type == REQ_COMMAND) begin
				saved_index = it.cmd_index;
				prefix_active = it.app_cmd;
				saved_arg = it.cmd_arg;
				byte_count = '0;
				poll_count = '0;
				start_command();
				return;
			end
			case (phase)
				PH_DESEL: begin
					cs_level = 1'b1;
					phase = PH_SEL;
					xfer(BYTE_FILL, 1'b1);
				end
				PH_SEL: begin
					phase = PH_READY;
					poll_count = '0;
					xfer(BYTE_FILL, cs_level);
				end
				PH_READY: begin
					if (it.rx_byte == BYTE_FILL) begin
						phase = PH_FRAME;
						byte_count = '0;
						xfer(frame_byte(3'd0), cs_level);
					end else if (poll_count >= cfg.ready_limit) begin
						cs_level = 1'b0;
						phase = PH_TOUT;
						xfer(BYTE_FILL, 1'b0);
					end else begin
						poll_count = poll_count + 16'd1;
						xfer(BYTE_FILL, cs_level);
					end
				end
				PH_FRAME: begin
					byte_count = byte_count + 3'd1;
					if (byte_count <= FRAME_LAST) begin
						xfer(frame_byte(byte_count), cs_level);
					end else begin
						byte_count = '0;
						poll_count = '0;
						phase = (active_index() == CMD_STOP) ? PH_DISCARD : PH_RESP;
						xfer(BYTE_FILL, cs_level);
					end
				end
				PH_DISCARD: begin
					phase = PH_RESP;
					poll_count = '0;
					xfer(BYTE_FILL, cs_level);
				end
				PH_RESP: begin
					if (!it.rx_byte[7]) begin
						complete(it.rx_byte, 1'b0);
					end else begin
						// zero limit wraps to a full 256 polls
						lim = (cfg.resp_poll_limit == 8'd0) ? 256 : int'(cfg.resp_poll_limit);
						poll_count = poll_count + 16'd1;
						if (int'(poll_count) >= lim)
							complete(it.rx_byte, 1'b0);
						else
							xfer(BYTE_FILL, cs_level);
					end
				end
				PH_TOUT: begin
					complete(BYTE_FILL, 1'b1);
				end
				default: begin
					phase = PH_IDLE;
				end
			endcase
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_exchange(rsp_t got);
			rsp_t want;
			if (pending_exchanges.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			want = pending_exchanges.pop_front();
			compare_field("out_kind", {7'd0, want.out_kind}, {7'd0, got.out_kind});
			compare_field("tx_byte", want.tx_byte, got.tx_byte);
			compare_field("cs_low", {7'd0, want.cs_low}, {7'd0, got.cs_low});
			compare_field("response", want.response, got.response);
			compare_field("timed_out", {7'd0, want.timed_out}, {7'd0, got.timed_out});
		endfunction
	endclass

endpackage

// ----- dv/sd_spi_command_engine_top_tb.sv -----
// testbench top for the sd spi command engine: stimulus, card responses and run control
`timescale 1ns / 100ps
module sd_spi_command_engine_top_tb;
	import sdspi_pkg::*;
	import sd_spi_command_engine_tb_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 128;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	req_t                req;
	logic                rsp_valid;
	logic                rsp_ready;
	rsp_t                rsp;
	logic                wr_en;
	logic [CfgIdxW-1:0]  wr_index;
	logic [CfgDataW-1:0] wr_data;

	spi_exchange_tracker tracker = new();

	int idle_cycles = 0;
	int req_quiet = 0;
	int rsp_quiet = 0;
	int busy_left = 0;
	int resp_wait = 0;
	bit ready_armed = 1'b0;
	bit resp_armed = 1'b0;

	sd_spi_command_engine_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	function automatic int pick_gap(inout int quiet);
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		if ($urandom_range(0, 39) == 0) begin
			quiet = int'($urandom_range(10, 60));
			return 0;
		end
		if ($urandom_range(0, 1) == 0)
			return int'($urandom_range(0, 2));
		return int'($urandom_range(0, 16));
	endfunction

	function automatic req_t rx_item(logic [7:0] b);
		req_t it;
		it.req_type = REQ_RX_BYTE;
		it.cmd_index = 6'($urandom);
		it.app_cmd = 1'($urandom);
		it.cmd_arg = $urandom;
		it.rx_byte = b;
		return it;
	endfunction

	function automatic req_t cmd_item(logic [5:0] idx, logic app, logic [31:0] arg);
		req_t it;
		it = rx_item(8'($urandom));
		it.req_type = REQ_COMMAND;
		it.cmd_index = idx;
		it.app_cmd = app;
		it.cmd_arg = arg;
		return it;
	endfunction

	// card side: answers what the engine is waiting for, with some noise
	function automatic req_t make_item(bit allow_noise);
		int unsigned lim;
		logic [5:0]  idx;
		if (allow_noise && $urandom_range(0, 49) == 0) begin
			if ($urandom_range(0, 1) == 0)
				return rx_item(8'($urandom));
			return cmd_item(6'($urandom), 1'($urandom), $urandom);
		end
		if (tracker.phase == PH_IDLE) begin
			case ($urandom_range(0, 5))
				0: idx = CMD_GO_IDLE;
				1: idx = CMD_IF_COND;
				2: idx = CMD_STOP;
				3: idx = CMD_APP;
				default: idx = 6'($urandom);
			endcase
			return cmd_item(idx, $urandom_range(0, 2) == 0, $urandom);
		end
		if (tracker.phase != PH_READY)
			ready_armed = 1'b0;
		if (tracker.phase != PH_RESP)
			resp_armed = 1'b0;
		case (tracker.phase)
			PH_READY: begin
				if (!ready_armed) begin
					ready_armed = 1'b1;
					lim = tracker.cfg.ready_limit;
					busy_left = (lim <= 8) ? int'($urandom_range(0, lim + 2))
						: int'($urandom_range(0, 3));
				end
				if (busy_left > 0) begin
					busy_left--;
					return rx_item(8'($urandom_range(0, 254)));
				end
				return rx_item(BYTE_FILL);
			end
			PH_RESP: begin
				if (!resp_armed) begin
					resp_armed = 1'b1;
					lim = (tracker.cfg.resp_poll_limit == 8'd0) ? 256
						: tracker.cfg.resp_poll_limit;
					resp_wait = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, lim))
						: int'($urandom_range(0, (lim < 4) ? lim : 4));
				end
				if (resp_wait > 0) begin
					resp_wait--;
					return rx_item(8'h80 | 8'($urandom_range(0, 127)));
				end
				if ($urandom_range(0, 3) == 0)
					return rx_item(8'($urandom_range(0, 127)));
				return rx_item(8'($urandom_range(0, 1)));
			end
			default: begin
				return rx_item(8'($urandom));
			end
		endcase
	endfunction

	task automatic send_item(input req_t it);
		int gap;
		gap = pick_gap(req_quiet);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		do
			@(posedge clk);
		while (!req_ready);
		tracker.note_request(it);
	endtask

	task automatic finish_sequence();
		while (tracker.phase != PH_IDLE)
			send_item(make_item(1'b0));
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_limits(input logic [15:0] ready, input logic [7:0] polls);
		wr_en <= 1'b1;
		wr_index <= CFG_READY_LIMIT;
		wr_data <= ready;
		@(posedge clk);
		wr_index <= CFG_RESP_POLL_LIMIT;
		wr_data <= {8'h00, polls};
		@(posedge clk);
		wr_en <= 1'b0;
		tracker.write_reg(CFG_READY_LIMIT, ready);
		tracker.write_reg(CFG_RESP_POLL_LIMIT, {8'h00, polls});
	endtask

	task automatic run_random(input int count);
		int   sent;
		req_t it;
		sent = 0;
		while (sent < count) begin
			it = make_item(1'b1);
			if (it.req_type == REQ_COMMAND || tracker.phase != PH_IDLE)
				sent++;
			send_item(it);
		end
	endtask

	// result side with random stalls
	initial begin
		int gap;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = pick_gap(rsp_quiet);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_valid);
			tracker.check_exchange(rsp);
		end
	end

	initial begin
		logic [15:0] ready;
		logic [7:0]  polls;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// received byte while idle
		send_item(rx_item(8'h5A));
		// full CMD0 exchange at reset limits
		send_item(cmd_item(CMD_GO_IDLE, 1'b0, 32'h0000_0000));
		send_item(rx_item(8'h00));
		send_item(rx_item(8'h3C));
		send_item(rx_item(BYTE_FILL));
		repeat (6) send_item(rx_item(8'($urandom)));
		send_item(rx_item(8'h01));
		// CMD12 with all-ones argument and the discarded byte
		send_item(cmd_item(CMD_STOP, 1'b0, 32'hFFFF_FFFF));
		repeat (7) send_item(rx_item(8'($urandom)));
		send_item(rx_item(8'h00));
		// app command abandoned by a new request
		send_item(cmd_item(CMD_IF_COND, 1'b1, 32'h0000_01AA));
		send_item(cmd_item(6'd63, 1'b1, 32'h8000_0001));
		finish_sequence();
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					ready = 16'd0;
					polls = 8'd1;
				end
				1: begin
					ready = 16'hFFFF;
					polls = 8'd255;
				end
				2: begin
					ready = 16'd2;
					polls = 8'd0;
				end
				3: begin
					ready = 16'd1;
					polls = 8'd3;
				end
				default: begin
					ready = ($urandom_range(0, 9) == 0) ? 16'($urandom)
						: 16'($urandom_range(0, 6));
					polls = ($urandom_range(0, 9) == 0) ? 8'($urandom)
						: 8'($urandom_range(0, 8));
				end
			endcase
			load_limits(ready, polls);
			run_random(ITEMS_PER_PHASE);
			finish_sequence();
			settle();
		end

		if (tracker.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
